/* src/gpool_pkg.sv */
// Shared constants and types for the generational slot pool.
`default_nettype none
package gpool_pkg;

  localparam int unsigned SLOTS     = 256;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned LINK_W    = IDX_W + 1;
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned HIDX_W    = 32;
  localparam int unsigned OUT_IDX_W = 8;
  localparam int unsigned CNT_W     = 9;

  // Link value that ends the free list.
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);
  localparam logic [GEN_W-1:0]  GEN_MAX   = '1;
  localparam logic [GEN_W-1:0]  GEN_INIT  = GEN_W'(1);

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  // One slot entry as kept in memory.
  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [LINK_W-1:0] link;
    logic              busy;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* src/gpool_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module gpool_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/generational_slot_pool_top.sv */
// Top level of the generational slot pool: handle allocator over a slot memory.
//
// Usage:
//   Raise start_i with op_i (0 = acquire, 1 = release) and, for a release, the
//   handle in handle_index_i / handle_generation_i. The transaction is taken at
//   a rising edge where start_i is high and busy_o is low.
//   Every transaction yields exactly one result, shown for one cycle with
//   done_o high: ok_o, slot_index_o, slot_generation_o and live_count_o.
// Timing:
//   The accept edge issues the memory read of the slot entry; the next edge
//   writes it back, updates the free-list head and live count and registers
//   the result, so done_o rises at that same edge. busy_o is high for the
//   cycle after each accept, so a new transaction is taken only once the
//   read-modify-write of the memory is complete.
// Reset:
//   Asynchronous, active low. Clears the per-slot valid bits, so every slot
//   reads as generation 1, link i+1, not busy, without a clearing pass. Free
//   list head is slot 0, live count 0. The block is ready right after reset.
// Back pressure:
//   None; the receiver must take done_o results when they appear.
`default_nettype none
module generational_slot_pool_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         op_i,
  input  wire logic [gpool_pkg::HIDX_W-1:0] handle_index_i,
  input  wire logic [gpool_pkg::GEN_W-1:0]  handle_generation_i,
  output logic                              done_o,
  output logic                              ok_o,
  output logic [gpool_pkg::OUT_IDX_W-1:0]   slot_index_o,
  output logic [gpool_pkg::GEN_W-1:0]       slot_generation_o,
  output logic [gpool_pkg::CNT_W-1:0]       live_count_o
);
  import gpool_pkg::*;

  // Sequencer: idle, then a single read-modify-write state.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e             state_q, state_d;
  op_e                op_q;
  logic [IDX_W-1:0]   slot_q;
  logic               range_err_q;
  logic [GEN_W-1:0]   gen_in_q;
  logic [LINK_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SLOTS-1:0]   valid_q;

  logic               done_q;
  logic               ok_q, ok_d;
  logic [OUT_IDX_W-1:0] idx_out_q, idx_out_d;
  logic [GEN_W-1:0]   gen_out_q, gen_out_d;

  logic               accept;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_entry;
  entry_t             cur;
  entry_t             wr_entry;
  logic               wr_en;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Acquire reads the head slot, release reads the slot named by the handle.
  assign rd_addr = (op_i == OP_RELEASE) ? handle_index_i[IDX_W-1:0]
                                        : head_q[IDX_W-1:0];

  gpool_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(slot_q),
    .wdata_i(wr_entry),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rd_entry)
  );

  // Entries never written read as their reset contents.
  always_comb begin
    if (valid_q[slot_q]) begin
      cur = rd_entry;
    end else begin
      cur.gen  = GEN_INIT;
      cur.link = LINK_W'({1'b0, slot_q}) + LINK_W'(1);
      cur.busy = 1'b0;
    end
  end

  // Read-modify-write of the slot entry. Reads and writes never overlap on
  // the same entry: a write happens only in S_EXEC, a read only at accept.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    wr_en     = 1'b0;
    wr_entry  = cur;
    ok_d      = 1'b0;
    idx_out_d = '0;
    gen_out_d = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (op_q == OP_ACQUIRE) begin
          if (head_q != LINK_NONE) begin
            wr_en         = 1'b1;
            wr_entry.busy = 1'b1;
            head_d        = cur.link;
            count_d       = count_q + CNT_W'(1);
            ok_d          = 1'b1;
            idx_out_d     = OUT_IDX_W'(slot_q);
            gen_out_d     = cur.gen;
          end
        end else begin
          if (!range_err_q && cur.busy && (cur.gen == gen_in_q)) begin
            wr_en         = 1'b1;
            wr_entry.busy = 1'b0;
            count_d       = count_q - CNT_W'(1);
            ok_d          = 1'b1;
            // Exhausted generation: slot retired, stays off the free list.
            if (cur.gen != GEN_MAX) begin
              wr_entry.gen  = cur.gen + GEN_W'(1);
              wr_entry.link = head_q;
              head_d        = LINK_W'({1'b0, slot_q});
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= (state_q == S_EXEC);
      if (wr_en) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  // Transaction and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_e'(op_i);
      slot_q      <= rd_addr;
      range_err_q <= (handle_index_i >= HIDX_W'(SLOTS));
      gen_in_q    <= handle_generation_i;
    end
    if (state_q == S_EXEC) begin
      ok_q      <= ok_d;
      idx_out_q <= idx_out_d;
      gen_out_q <= gen_out_d;
    end
  end

  assign done_o            = done_q;
  assign ok_o              = ok_q;
  assign slot_index_o      = idx_out_q;
  assign slot_generation_o = gen_out_q;
  assign live_count_o      = count_q;

endmodule
`default_nettype wire

/* tb/tb_generational_slot_pool_top.sv */
// Self-checking testbench for the generational slot pool: directed and random handle traffic.
`timescale 1ns / 1ps
module tb_generational_slot_pool_top;
  import gpool_pkg::*;

  localparam int unsigned CLK_PERIOD  = 4;
  localparam int unsigned ITEMS       = 1100;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // One transaction toward the pool.
  typedef struct {
    op_e               op;
    logic [HIDX_W-1:0] idx;
    logic [GEN_W-1:0]  gen;
  } pool_req_t;

  // One reply the pool owes us.
  typedef struct {
    logic                 ok;
    logic [OUT_IDX_W-1:0] idx;
    logic [GEN_W-1:0]     gen;
    logic [CNT_W-1:0]     cnt;
  } pool_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 op_i = 1'b0;
  logic [HIDX_W-1:0]    handle_index_i = '0;
  logic [GEN_W-1:0]     handle_generation_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic                 ok_o;
  logic [OUT_IDX_W-1:0] slot_index_o;
  logic [GEN_W-1:0]     slot_generation_o;
  logic [CNT_W-1:0]     live_count_o;

  // Shadow copy of the pool, advanced at every accepted transaction.
  logic [GEN_W-1:0]  pool_gen   [SLOTS];
  logic [LINK_W-1:0] pool_link  [SLOTS];
  bit                pool_taken [SLOTS];
  logic [LINK_W-1:0] shadow_head;
  logic [CNT_W-1:0]  live_cnt;

  pool_req_t   op_backlog[$];       // transactions waiting for the driver
  pool_reply_t pending_replies[$];  // replies predicted, not yet seen
  pool_reply_t want_reply;

  int unsigned sent_cnt  = 0;
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left  = 0;
  bit          calm_tail = 1'b0;

  generational_slot_pool_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .op_i                (op_i),
    .handle_index_i      (handle_index_i),
    .handle_generation_i (handle_generation_i),
    .done_o              (done_o),
    .ok_o                (ok_o),
    .slot_index_o        (slot_index_o),
    .slot_generation_o   (slot_generation_o),
    .live_count_o        (live_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pool prediction
  // ---------------------------------------------------------------------------

  // Reset image: chain 0 -> 1 -> ... -> SLOTS-1 -> none, every generation 1.
  task automatic clear_pool();
    for (int unsigned i = 0; i < SLOTS; i++) begin
      pool_gen[i]   = GEN_INIT;
      pool_link[i]  = LINK_W'(i + 1);
      pool_taken[i] = 1'b0;
    end
    shadow_head = '0;
    live_cnt    = '0;
  endtask

  // Apply one accepted transaction to the shadow pool and queue its reply.
  task automatic apply_pool_op(input op_e op, input logic [HIDX_W-1:0] hidx,
                               input logic [GEN_W-1:0] hgen);
    pool_reply_t      r;
    logic [IDX_W-1:0] s;
    r = '{ok: 1'b0, idx: '0, gen: '0, cnt: '0};
    if (op == OP_ACQUIRE) begin
      // Pop the head; an empty list leaves everything untouched.
      if (shadow_head < LINK_W'(SLOTS)) begin
        s             = shadow_head[IDX_W-1:0];
        shadow_head   = pool_link[s];
        pool_taken[s] = 1'b1;
        live_cnt      = live_cnt + CNT_W'(1);
        r.ok          = 1'b1;
        r.idx         = OUT_IDX_W'(s);
        r.gen         = pool_gen[s];
      end
    end else if (hidx < HIDX_W'(SLOTS)) begin
      s = hidx[IDX_W-1:0];
      // Stale or foreign handles are rejected without side effects.
      if (pool_taken[s] && pool_gen[s] == hgen) begin
        pool_taken[s] = 1'b0;
        live_cnt      = live_cnt - CNT_W'(1);
        r.ok          = 1'b1;
        // A slot at the top generation is retired instead of recycled.
        if (pool_gen[s] != GEN_MAX) begin
          pool_gen[s]  = pool_gen[s] + GEN_W'(1);
          pool_link[s] = shadow_head;
          shadow_head  = LINK_W'(s);
        end
      end
    end
    r.cnt = live_cnt;
    pending_replies.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transaction in flight from the backlog, random idle bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i             <= 1'b0;
      op_i                <= 1'b0;
      handle_index_i      <= '0;
      handle_generation_i <= '0;
      gap_left             = 0;
    end else begin
      if (start_i && !busy_o) begin
        apply_pool_op(op_e'(op_i), handle_index_i, handle_generation_i);
        void'(op_backlog.pop_front());
        if (!calm_tail && $urandom_range(3) == 0) begin
          gap_left = $urandom_range(1, 4);
        end
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start_i <= 1'b0;
      end else if (op_backlog.size() != 0) begin
        start_i             <= 1'b1;
        op_i                <= op_backlog[0].op;
        handle_index_i      <= op_backlog[0].idx;
        handle_generation_i <= op_backlog[0].gen;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done_o pulse is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [GEN_W-1:0] want,
                                      input logic [GEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_cnt++;
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("ok", GEN_W'(want_reply.ok), GEN_W'(ok_o));
        check_field("slot_index", GEN_W'(want_reply.idx), GEN_W'(slot_index_o));
        check_field("slot_generation", want_reply.gen, slot_generation_o);
        check_field("live_count", GEN_W'(want_reply.cnt), GEN_W'(live_count_o));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("generational_slot_pool_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Items are built one at a time, once the previous one has been
  // taken, so releases can pick handles that are live in the shadow pool.
  // ---------------------------------------------------------------------------
  task automatic await_backlog();
    while (op_backlog.size() != 0) @(negedge clk_i);
  endtask

  // Hold the sender until the pool has answered everything.
  task automatic await_quiet();
    while (op_backlog.size() != 0 || pending_replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_op(input op_e op, input logic [HIDX_W-1:0] idx,
                         input logic [GEN_W-1:0] gen);
    await_backlog();
    op_backlog.push_back('{op: op, idx: idx, gen: gen});
    sent_cnt++;
  endtask

  // Rejects mostly: wide indexes, random or off-by-one generations, just past the end.
  task automatic send_noise_release();
    logic [HIDX_W-1:0] idx;
    await_backlog();
    idx = $urandom_range(SLOTS - 1);
    case ($urandom_range(3))
      0: send_op(OP_RELEASE, $urandom, $urandom);
      1: send_op(OP_RELEASE, idx, $urandom);
      2: send_op(OP_RELEASE, idx, pool_gen[idx[IDX_W-1:0]] - $urandom_range(1));
      default: send_op(OP_RELEASE, SLOTS + $urandom_range(3), pool_gen[idx[IDX_W-1:0]]);
    endcase
  endtask

  // Release a handle that is live right now, or a noise release when none is live.
  task automatic send_live_release();
    int unsigned slot;
    await_backlog();
    if (live_cnt == 0) begin
      send_noise_release();
    end else begin
      slot = $urandom_range(SLOTS - 1);
      while (!pool_taken[slot]) slot = (slot + 1) % SLOTS;
      send_op(OP_RELEASE, slot, pool_gen[slot]);
    end
  endtask

  task automatic send_mixed(input int unsigned pct_acq, input int unsigned pct_live);
    int unsigned r;
    r = $urandom_range(99);
    if (r < pct_acq) begin
      send_op(OP_ACQUIRE, $urandom, $urandom);
    end else if (r < pct_acq + pct_live) begin
      send_live_release();
    end else begin
      send_noise_release();
    end
  endtask

  initial begin
    int unsigned pct_acq;
    clear_pool();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: rejects on a fresh pool, index extremes, stale handles,
    // LIFO reuse with bumped generation, ignored fields on acquire.
    send_op(OP_RELEASE, 0, GEN_INIT);             // slot never handed out
    send_op(OP_RELEASE, '1, GEN_MAX);             // index far out of range
    send_op(OP_RELEASE, SLOTS, GEN_INIT);         // first index past the end
    send_op(OP_ACQUIRE, '0, '0);
    send_op(OP_ACQUIRE, '1, '1);
    send_op(OP_RELEASE, 0, GEN_INIT + GEN_W'(1)); // generation from the future
    send_op(OP_RELEASE, 0, GEN_MAX);
    send_op(OP_RELEASE, 0, GEN_INIT);
    send_op(OP_RELEASE, 0, GEN_INIT);             // double release
    send_op(OP_ACQUIRE, '0, '0);                  // slot 0 back, generation 2
    send_op(OP_RELEASE, SLOTS - 1, GEN_INIT);     // top index, not live
    send_op(OP_RELEASE, 1, '0);
    send_op(OP_RELEASE, 1, GEN_INIT);
    send_op(OP_ACQUIRE, '1, '0);
    send_op(OP_RELEASE, 32'h8000_0000, GEN_INIT);
    send_op(OP_RELEASE, 0, GEN_INIT);             // stale generation after reuse
    await_quiet();

    // Fill the pool completely, then hit the empty free list.
    await_backlog();
    while (shadow_head < LINK_W'(SLOTS)) begin
      send_mixed(90, 5);
      await_backlog();
    end
    repeat (3) send_op(OP_ACQUIRE, $urandom, $urandom);
    await_quiet();

    // Drain every live handle in random order.
    await_backlog();
    while (live_cnt != 0) begin
      send_mixed(5, 85);
      await_backlog();
    end

    // Mixed traffic with a drifting acquire/release balance.
    while (sent_cnt < ITEMS) begin
      pct_acq = $urandom_range(20, 80);
      repeat (100) begin
        if (sent_cnt + 100 >= ITEMS) calm_tail = 1'b1;
        send_mixed(pct_acq, (100 - pct_acq) * 4 / 5);
      end
      if ($urandom_range(2) == 0) await_quiet();
    end

    await_quiet();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("generational_slot_pool_top regression: pass");
    end else begin
      $display("generational_slot_pool_top regression: fail");
    end
    $finish;
  end

endmodule
